// ===== rtl/core/pwm_calc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_calc_pkg
// Shared widths, constants and payload types of the PWM timer setting
// calculator.
// ----------------------------------------------------------------------------
package pwm_calc_pkg;

	localparam int FREQ_W   = 12;
	localparam int DUTY_W   = 7;
	localparam int CODE_W   = 2;
	localparam int COUNT_W  = 7;
	localparam int DIVD_W   = 14;   // largest dividend is 16000
	localparam int PROD_W   = 13;   // period * duty stays below 6500
	localparam int SCALE_W  = 26;

	localparam logic [FREQ_W-1:0] FREQ_MAX     = FREQ_W'(4000);
	localparam logic [DUTY_W-1:0] DUTY_MAX     = DUTY_W'(100);
	localparam logic [FREQ_W-1:0] FREQ_LIM_256 = FREQ_W'(4);
	localparam logic [FREQ_W-1:0] FREQ_LIM_64  = FREQ_W'(31);
	localparam logic [FREQ_W-1:0] FREQ_LIM_8   = FREQ_W'(245);

	localparam logic [DIVD_W-1:0] DIV_256 = DIVD_W'(62);
	localparam logic [DIVD_W-1:0] DIV_64  = DIVD_W'(250);
	localparam logic [DIVD_W-1:0] DIV_8   = DIVD_W'(2000);
	localparam logic [DIVD_W-1:0] DIV_1   = DIVD_W'(16000);

	localparam logic [CODE_W-1:0] CODE_PS1   = 2'd0;
	localparam logic [CODE_W-1:0] CODE_PS8   = 2'd1;
	localparam logic [CODE_W-1:0] CODE_PS64  = 2'd2;
	localparam logic [CODE_W-1:0] CODE_PS256 = 2'd3;

	// x / 100 == (x * 5243) >> 19 for every x below 6500
	localparam logic [SCALE_W-1:0] RECIP_100 = SCALE_W'(5243);
	localparam int                 RECIP_SH  = 19;

	// quotient bits produced by the divider, one per stage
	localparam int DIV_STAGES_DEF = COUNT_W;

	typedef struct packed {
		logic              en;
		logic [CODE_W-1:0] code;
		logic [DUTY_W-1:0] duty;
	} meta_t;

	typedef struct packed {
		meta_t             meta;
		logic [DIVD_W-1:0] dividend;
		logic [FREQ_W-1:0] divisor;
	} front_t;

	typedef struct packed {
		meta_t              meta;
		logic [COUNT_W-1:0] quot;
	} divq_t;

endpackage
`default_nettype wire

// ===== rtl/core/pwm_calc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_calc_in_if / pwm_calc_out_if
// Request and result channels of the PWM timer setting calculator.
// ----------------------------------------------------------------------------
interface pwm_calc_in_if;
	logic                             valid;
	logic                             ready;
	logic [pwm_calc_pkg::FREQ_W-1:0]  freq_khz;
	logic [pwm_calc_pkg::DUTY_W-1:0]  duty_percent;

	modport source (output valid, output freq_khz, output duty_percent, input ready);
	modport sink   (input valid, input freq_khz, input duty_percent, output ready);
endinterface

interface pwm_calc_out_if;
	logic                             valid;
	logic                             ready;
	logic                             output_enable;
	logic [pwm_calc_pkg::CODE_W-1:0]  prescale_code;
	logic [pwm_calc_pkg::COUNT_W-1:0] period_count;
	logic [pwm_calc_pkg::COUNT_W-1:0] compare_count;

	modport source (output valid, output output_enable, output prescale_code,
		output period_count, output compare_count, input ready);
	modport sink   (input valid, input output_enable, input prescale_code,
		input period_count, input compare_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pwm_calc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_calc_front
// Saturates the request and picks prescaler code and divisor.
// ----------------------------------------------------------------------------
module pwm_calc_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic [pwm_calc_pkg::FREQ_W-1:0] freq_khz,
	input  wire logic [pwm_calc_pkg::DUTY_W-1:0] duty_percent,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      pwm_calc_pkg::front_t            out_data
);

	logic                            valid_s1;
	pwm_calc_pkg::front_t            data_s1;
	pwm_calc_pkg::front_t            nxt;
	logic [pwm_calc_pkg::FREQ_W-1:0] freq;
	logic [pwm_calc_pkg::DUTY_W-1:0] duty;
	logic                            adv;

	always_comb begin
		freq = (freq_khz > pwm_calc_pkg::FREQ_MAX) ? pwm_calc_pkg::FREQ_MAX : freq_khz;
		duty = (duty_percent > pwm_calc_pkg::DUTY_MAX) ? pwm_calc_pkg::DUTY_MAX : duty_percent;
		nxt.meta.en   = (freq != '0);
		nxt.meta.duty = duty;
		nxt.divisor   = freq;
		if (freq == '0) begin
			// output off: divide 0 by 1, result is masked later
			nxt.meta.code = pwm_calc_pkg::CODE_PS1;
			nxt.dividend  = '0;
			nxt.divisor   = pwm_calc_pkg::FREQ_W'(1);
		end else if (freq < pwm_calc_pkg::FREQ_LIM_256) begin
			nxt.meta.code = pwm_calc_pkg::CODE_PS256;
			nxt.dividend  = pwm_calc_pkg::DIV_256;
		end else if (freq < pwm_calc_pkg::FREQ_LIM_64) begin
			nxt.meta.code = pwm_calc_pkg::CODE_PS64;
			nxt.dividend  = pwm_calc_pkg::DIV_64;
		end else if (freq < pwm_calc_pkg::FREQ_LIM_8) begin
			nxt.meta.code = pwm_calc_pkg::CODE_PS8;
			nxt.dividend  = pwm_calc_pkg::DIV_8;
		end else begin
			nxt.meta.code = pwm_calc_pkg::CODE_PS1;
			nxt.dividend  = pwm_calc_pkg::DIV_1;
		end
	end

	assign adv      = !valid_s1 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// ===== rtl/core/pwm_calc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_calc_div
// Pipelined restoring divider, one quotient bit per stage, msb first.
// ----------------------------------------------------------------------------
module pwm_calc_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire pwm_calc_pkg::front_t in_data,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      pwm_calc_pkg::divq_t  out_data
);

	localparam int DIV_STAGES = pwm_calc_pkg::DIV_STAGES_DEF;
	localparam int REM_W   = pwm_calc_pkg::DIVD_W;
	localparam int DSR_W   = pwm_calc_pkg::FREQ_W;
	localparam int Q_W     = pwm_calc_pkg::COUNT_W;
	localparam int TRIAL_W = DSR_W + DIV_STAGES + 1;

	logic [DIV_STAGES-1:0] valid_s;
	logic [DIV_STAGES-1:0] adv;
	logic [REM_W-1:0]      rem_s  [DIV_STAGES];
	logic [DSR_W-1:0]      dsr_s  [DIV_STAGES];
	logic [Q_W-1:0]        quot_s [DIV_STAGES];
	pwm_calc_pkg::meta_t   meta_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		localparam int SH = DIV_STAGES - 1 - g;

		logic                cur_v;
		logic [REM_W-1:0]    cur_rem;
		logic [DSR_W-1:0]    cur_dsr;
		logic [Q_W-1:0]      cur_quot;
		pwm_calc_pkg::meta_t cur_meta;
		logic [TRIAL_W-1:0]  trial;
		logic [TRIAL_W-1:0]  rem_ext;
		logic                fits;
		logic                nxt_ready;

		if (g == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_rem  = in_data.dividend;
			assign cur_dsr  = in_data.divisor;
			assign cur_quot = '0;
			assign cur_meta = in_data.meta;
		end else begin : g_next
			assign cur_v    = valid_s[g-1];
			assign cur_rem  = rem_s[g-1];
			assign cur_dsr  = dsr_s[g-1];
			assign cur_quot = quot_s[g-1];
			assign cur_meta = meta_s[g-1];
		end

		if (g == DIV_STAGES - 1) begin : g_last
			assign nxt_ready = out_ready;
		end else begin : g_mid
			assign nxt_ready = adv[g+1];
		end

		assign trial   = TRIAL_W'(cur_dsr) << SH;
		assign rem_ext = TRIAL_W'(cur_rem);
		assign fits    = (rem_ext >= trial);
		assign adv[g]  = !valid_s[g] || nxt_ready;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (adv[g]) begin
				valid_s[g] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g] && cur_v) begin
				rem_s[g]  <= fits ? REM_W'(rem_ext - trial) : cur_rem;
				quot_s[g] <= fits ? (cur_quot | (Q_W'(1) << SH)) : cur_quot;
				dsr_s[g]  <= cur_dsr;
				meta_s[g] <= cur_meta;
			end
		end
	end

	assign in_ready       = adv[0];
	assign out_valid      = valid_s[DIV_STAGES-1];
	assign out_data.meta  = meta_s[DIV_STAGES-1];
	assign out_data.quot  = quot_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/pwm_calc_duty.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_calc_duty
// Forms the period and the compare value (period * duty / 100) in two stages.
// ----------------------------------------------------------------------------
module pwm_calc_duty (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire pwm_calc_pkg::divq_t in_data,
	pwm_calc_out_if.source           res
);

	localparam int CW = pwm_calc_pkg::COUNT_W;
	localparam int PW = pwm_calc_pkg::PROD_W;
	localparam int SW = pwm_calc_pkg::SCALE_W;

	logic                              valid_s1, valid_s2;
	logic                              en_s1, en_s2;
	logic [pwm_calc_pkg::CODE_W-1:0]   code_s1, code_s2;
	logic [CW-1:0]                     period_s1, period_s2;
	logic [PW-1:0]                     prod_s1;
	logic [SW-1:0]                     scaled_s2;
	logic [CW-1:0]                     period;
	logic                              adv1, adv2;

	assign period = in_data.meta.en ? (in_data.quot - CW'(1)) : '0;

	assign adv2     = !valid_s2 || res.ready;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			en_s1     <= in_data.meta.en;
			code_s1   <= in_data.meta.en ? in_data.meta.code : pwm_calc_pkg::CODE_PS1;
			period_s1 <= period;
			prod_s1   <= PW'(period) * PW'(in_data.meta.duty);
		end
		if (adv2 && valid_s1) begin
			en_s2     <= en_s1;
			code_s2   <= code_s1;
			period_s2 <= period_s1;
			// divide by 100 through a reciprocal
			scaled_s2 <= SW'(prod_s1) * pwm_calc_pkg::RECIP_100;
		end
	end

	assign res.valid         = valid_s2;
	assign res.output_enable = en_s2;
	assign res.prescale_code = code_s2;
	assign res.period_count  = period_s2;
	assign res.compare_count = scaled_s2[pwm_calc_pkg::RECIP_SH +: CW];

endmodule
`default_nettype wire

// ===== rtl/core/pwm_timer_setting_calc_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_timer_setting_calc_top
// Turns a PWM frequency in kHz and a duty cycle in percent into prescaler
// code, period and compare values for a timer.
//
//   channel   dir  handshake     payload
//   req_in    in   valid/ready   freq_khz[11:0], duty_percent[6:0]
//   res_out   out  valid/ready   output_enable, prescale_code[1:0],
//                                period_count[6:0], compare_count[6:0]
//
// one request per cycle while the result side keeps taking results; stages:
// one select stage, one divider stage per quotient bit, two multiply stages
// each stage holds its item until the next one has room, bubbles close up
// reset clears only the valid bits, so the pipeline comes up empty
// a stalled result keeps its register; requests keep entering until full
// ----------------------------------------------------------------------------
module pwm_timer_setting_calc_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pwm_calc_in_if.sink     req_in,
	pwm_calc_out_if.source  res_out
);

	logic                 front_valid, front_ready;
	pwm_calc_pkg::front_t front_data;
	logic                 div_valid, div_ready;
	pwm_calc_pkg::divq_t  div_data;

	pwm_calc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req_in.valid),
		.in_ready     (req_in.ready),
		.freq_khz     (req_in.freq_khz),
		.duty_percent (req_in.duty_percent),
		.out_valid    (front_valid),
		.out_ready    (front_ready),
		.out_data     (front_data)
	);

	pwm_calc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	pwm_calc_duty u_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_data  (div_data),
		.res      (res_out)
	);

	// output off means every count is zero
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && !res_out.output_enable) |->
		(res_out.prescale_code == pwm_calc_pkg::CODE_PS1 &&
		 res_out.period_count == '0 && res_out.compare_count == '0))
		else $error("disabled result carries nonzero settings");

	a_cmp_le_period: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.compare_count <= res_out.period_count))
		else $error("compare value exceeds period");

	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.period_count <= pwm_calc_pkg::COUNT_W'(64)))
		else $error("period out of range");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid && !div_ready) |=> (div_valid && $stable(div_data)))
		else $error("divider output changed while stalled");

endmodule
`default_nettype wire

// ===== bench/pwm_timer_setting_calc_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_timer_setting_calc_top_tb
// Self-checking bench for the PWM timer setting calculator. Requests of
// frequency and duty go in over the request channel with random gaps. Each
// accepted request is run through a local model of the prescaler, period and
// compare computation. Every result is checked in order against the oldest
// expected setting. The run covers band edges, saturation, output off,
// random traffic and a long result stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module pwm_timer_setting_calc_top_tb;

	localparam int PIPE_LATENCY  = pwm_calc_pkg::DIV_STAGES_DEF + 3;
	localparam int DRAIN_CYCLES  = 4 * PIPE_LATENCY;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_COUNT  = 700;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic                             en;
		logic [pwm_calc_pkg::CODE_W-1:0]  code;
		logic [pwm_calc_pkg::COUNT_W-1:0] period;
		logic [pwm_calc_pkg::COUNT_W-1:0] cmp;
	} pwm_setting_t;

	logic clk;
	logic arst_n;

	pwm_calc_in_if  req_if();
	pwm_calc_out_if res_if();

	pwm_timer_setting_calc_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_in  (req_if),
		.res_out (res_if)
	);

	pwm_setting_t pending_settings[$];
	int errors        = 0;
	int requests_sent = 0;
	int settings_seen = 0;
	int off_requests  = 0;
	int sat_requests  = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;
	bit sender_steady = 0;
	bit sink_steady   = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// expected timer setting for one request
	function automatic pwm_setting_t calc_setting(logic [pwm_calc_pkg::FREQ_W-1:0] f_in,
			logic [pwm_calc_pkg::DUTY_W-1:0] d_in);
		int f;
		int d;
		int divisor;
		int per;
		int cmpv;
		pwm_setting_t s;
		f = (f_in > pwm_calc_pkg::FREQ_MAX) ? int'(pwm_calc_pkg::FREQ_MAX) : int'(f_in);
		d = (d_in > pwm_calc_pkg::DUTY_MAX) ? int'(pwm_calc_pkg::DUTY_MAX) : int'(d_in);
		s = '0;
		if (f == 0)
			return s;
		if (f < int'(pwm_calc_pkg::FREQ_LIM_256)) begin
			divisor = int'(pwm_calc_pkg::DIV_256);
			s.code = pwm_calc_pkg::CODE_PS256;
		end else if (f < int'(pwm_calc_pkg::FREQ_LIM_64)) begin
			divisor = int'(pwm_calc_pkg::DIV_64);
			s.code = pwm_calc_pkg::CODE_PS64;
		end else if (f < int'(pwm_calc_pkg::FREQ_LIM_8)) begin
			divisor = int'(pwm_calc_pkg::DIV_8);
			s.code = pwm_calc_pkg::CODE_PS8;
		end else begin
			divisor = int'(pwm_calc_pkg::DIV_1);
			s.code = pwm_calc_pkg::CODE_PS1;
		end
		per = divisor / f - 1;
		cmpv = (per * d) / 100;
		s.en = 1'b1;
		s.period = per[pwm_calc_pkg::COUNT_W-1:0];
		s.cmp = cmpv[pwm_calc_pkg::COUNT_W-1:0];
		return s;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// one request; leaves valid high after acceptance so back-to-back stays clean
	task automatic send_request(input logic [pwm_calc_pkg::FREQ_W-1:0] f,
			input logic [pwm_calc_pkg::DUTY_W-1:0] d);
		int gap;
		gap = 0;
		if (!sender_steady && $urandom_range(99) < 7)
			gap = 1;
		repeat (gap) begin
			@(negedge clk);
			req_if.valid = 1'b0;
		end
		@(negedge clk);
		req_if.valid = 1'b1;
		req_if.freq_khz = f;
		req_if.duty_percent = d;
		do @(posedge clk); while (!req_if.ready);
		pending_settings.push_back(calc_setting(f, d));
		requests_sent++;
		if (f == 0)
			off_requests++;
		if (f > pwm_calc_pkg::FREQ_MAX || d > pwm_calc_pkg::DUTY_MAX)
			sat_requests++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_if.valid = 1'b0;
	endtask

	// band edges, saturation and output off
	task automatic test_directed();
		sender_steady = 1;
		sink_steady = 1;
		send_request(12'd0, 7'd50);
		send_request(12'd0, 7'd127);
		send_request(12'd1, 7'd0);
		send_request(12'd1, 7'd100);
		send_request(12'd2, 7'd33);
		send_request(12'd3, 7'd100);
		send_request(12'd4, 7'd100);
		send_request(12'd4, 7'd1);
		send_request(12'd30, 7'd99);
		send_request(12'd31, 7'd100);
		send_request(12'd31, 7'd50);
		send_request(12'd244, 7'd100);
		send_request(12'd245, 7'd100);
		send_request(12'd245, 7'd64);
		send_request(12'd4000, 7'd100);
		send_request(12'd4000, 7'd0);
		send_request(12'd4001, 7'd75);
		send_request(12'd4095, 7'd127);
		send_request(12'd2048, 7'd101);
		send_request(12'd1365, 7'd42);
		send_request(12'd100, 7'd127);
		send_request(12'd0, 7'd0);
		stop_sending();
		sender_steady = 0;
		sink_steady = 0;
	endtask

	// mostly in-range requests spread over the bands, some saturating and off
	task automatic test_random();
		logic [pwm_calc_pkg::FREQ_W-1:0] f;
		logic [pwm_calc_pkg::DUTY_W-1:0] d;
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			// first stretch runs without any idling on either side
			sender_steady = (i < 150);
			sink_steady = (i < 150);
			case ($urandom_range(9))
				0: f = '0;
				1: f = pwm_calc_pkg::FREQ_W'($urandom_range(1, 3));
				2: f = pwm_calc_pkg::FREQ_W'($urandom_range(4, 30));
				3: f = pwm_calc_pkg::FREQ_W'($urandom_range(31, 244));
				4, 5: f = pwm_calc_pkg::FREQ_W'($urandom_range(245, 4000));
				6: f = pwm_calc_pkg::FREQ_W'($urandom_range(4001, 4095));
				default: f = pwm_calc_pkg::FREQ_W'($urandom_range(0, 4095));
			endcase
			case ($urandom_range(9))
				0: d = pwm_calc_pkg::DUTY_W'($urandom_range(101, 127));
				1: d = pwm_calc_pkg::DUTY_W'($urandom_range(0, 127));
				default: d = pwm_calc_pkg::DUTY_W'($urandom_range(0, 100));
			endcase
			send_request(f, d);
		end
		stop_sending();
		sender_steady = 0;
		sink_steady = 0;
	endtask

	// results held off for a long stretch while requests keep coming
	task automatic test_backpressure();
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		sender_steady = 1;
		for (int i = 0; i < 40; i++)
			send_request(12'($urandom_range(0, 4095)), 7'($urandom_range(0, 127)));
		stop_sending();
		sender_steady = 0;
	endtask

	// result side: long hold when asked, always ready when steady, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_if.ready = 1'b0;
			hold_left--;
		end else if (sink_steady) begin
			res_if.ready = 1'b1;
		end else begin
			res_if.ready = ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		pwm_setting_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			settings_seen++;
			if (pending_settings.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_settings.pop_front();
				if (res_if.output_enable !== want.en)
					report_mismatch("output_enable", res_if.output_enable, want.en);
				if (res_if.prescale_code !== want.code)
					report_mismatch("prescale_code", res_if.prescale_code, want.code);
				if (res_if.period_count !== want.period)
					report_mismatch("period_count", res_if.period_count, want.period);
				if (res_if.compare_count !== want.cmp)
					report_mismatch("compare_count", res_if.compare_count, want.cmp);
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_settings.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.freq_khz = '0;
		req_if.duty_percent = '0;
		res_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();
		test_backpressure();

		while (pending_settings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_settings.size() != 0)
			report_mismatch("missing results", 0, pending_settings.size());
		$display("covered %0d requests (%0d output off, %0d saturated), %0d results checked",
			requests_sent, off_requests, sat_requests, settings_seen);
		$display("directed band edges, random traffic with stalls, %0d-cycle result hold",
			HOLD_CYCLES);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
